>>> hdl/brca_pkg.sv
// Shared types and constants for the bilinear resize / channel adapt block.
// No dependencies.
`default_nettype none
package brca_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [7:0] MAX_IN_DIM   = 8'd128;
    localparam logic [7:0] MAX_OUT_DIM  = 8'd64;
    localparam logic [7:0] MAX_CHANNELS = 8'd4;

    localparam logic [2:0] REG_IN_HEIGHT    = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH     = 3'd1;
    localparam logic [2:0] REG_IN_CHANNELS  = 3'd2;
    localparam logic [2:0] REG_OUT_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_OUT_WIDTH    = 3'd4;
    localparam logic [2:0] REG_OUT_CHANNELS = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] sample_value;
        logic [1:0]  channel_index;
        logic        last_in_pixel;
        logic        last_in_frame;
    } out_item_t;

    // Zero counts as one, anything above hi counts as hi.
    function automatic logic [7:0] clamp_dim(input logic [7:0] v, input logic [7:0] hi);
        logic [7:0] r;
        if (v == 8'd0)
            r = 8'd1;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/bilinear_resize_channel_adapt_core.sv
// Bilinear frame resizer with channel adaptation: frame store, sequencer,
// shared restoring divider and multiply-accumulate. Depends on brca_pkg.
`default_nettype none
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    brca_pkg::in_item_t (cmd, pixel_value)
// out       output     out_valid/out_ready  brca_pkg::out_item_t (one per out channel)
// cfg       input      cfg_we               cfg_index, cfg_data (write only)
//
// A load transaction writes the store, then computes the frame size and checks
// the load pointer for wrap. An emit transaction first runs its setup (two
// divisions for the scales, two axis passes, four corner weights) and then,
// per output channel, a setup step, a read and accumulate of the four corners
// per averaged input channel, a rounding division on the shared divider and
// the output handshake.
// Reset clears control state; the frame store is not cleared. While an item
// is in progress in_ready is low; a stalled result holds in the output register.
module bilinear_resize_channel_adapt_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  brca_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output brca_pkg::out_item_t  out_data,
    input  wire                  cfg_we,
    input  wire  [2:0]           cfg_index,
    input  wire  [7:0]           cfg_data
);
    import brca_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_LD1  = 13'b0000000000010,
        ST_LD2  = 13'b0000000000100,
        ST_DIVR = 13'b0000000001000,
        ST_DIVC = 13'b0000000010000,
        ST_AXM  = 13'b0000000100000,
        ST_AXF  = 13'b0000001000000,
        ST_WGT  = 13'b0000010000000,
        ST_CH   = 13'b0000100000000,
        ST_RD   = 13'b0001000000000,
        ST_MAC  = 13'b0010000000000,
        ST_QD   = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [7:0] in_height_reg, in_width_reg;
    logic [2:0] in_channels_reg, out_channels_reg;
    logic [6:0] out_height_reg, out_width_reg;

    logic [7:0] ih, iw;
    logic [2:0] ic, ocn;
    logic [6:0] oh, ow;
    logic [7:0] ic_w, ocn_w, oh_w, ow_w;

    assign ih    = clamp_dim(in_height_reg, MAX_IN_DIM);
    assign iw    = clamp_dim(in_width_reg, MAX_IN_DIM);
    assign ic_w  = clamp_dim({5'b0, in_channels_reg}, MAX_CHANNELS);
    assign ocn_w = clamp_dim({5'b0, out_channels_reg}, MAX_CHANNELS);
    assign oh_w  = clamp_dim({1'b0, out_height_reg}, MAX_OUT_DIM);
    assign ow_w  = clamp_dim({1'b0, out_width_reg}, MAX_OUT_DIM);
    assign ic    = ic_w[2:0];
    assign ocn   = ocn_w[2:0];
    assign oh    = oh_w[6:0];
    assign ow    = ow_w[6:0];

    // frame store and position state
    logic [7:0]  frame_mem [0:65535];
    logic [7:0]  rdata_reg;
    logic [15:0] load_ptr_reg;
    logic [14:0] hw_reg;
    logic [5:0]  out_row_reg, out_col_reg;
    logic [23:0] row_scale_reg, col_scale_reg;

    // shared restoring divider
    logic [23:0] div_quo_reg;
    logic [6:0]  div_rem_reg;
    logic [6:0]  div_den_reg;
    logic [4:0]  div_cnt_reg;
    logic [7:0]  div_trial;
    logic        div_ge;
    logic        div_done;

    assign div_trial = {div_rem_reg, div_quo_reg[23]};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};
    assign div_done  = div_cnt_reg == 5'd24;

    // axis setup
    logic        ax_sel_reg;
    logic [30:0] prod_reg;
    logic [5:0]  ax_o;
    logic [23:0] ax_s;
    logic [30:0] ax_prod;
    logic signed [31:0] ax_t, ax_c;
    logic signed [15:0] ax_f, ax_f1, ax_lim;
    logic [15:0] ax_w1;
    logic [16:0] ax_w0;
    logic [6:0]  ax_a, ax_b;
    logic [7:0]  ax_dim;

    assign ax_o    = ax_sel_reg ? out_col_reg : out_row_reg;
    assign ax_s    = ax_sel_reg ? col_scale_reg : row_scale_reg;
    assign ax_prod = 31'({ax_o, 1'b1} * ax_s);
    assign ax_t    = $signed({1'b0, prod_reg}) - 32'sd65536;
    assign ax_c    = ax_t >>> 1;
    assign ax_f    = ax_c[31:16];
    assign ax_f1   = ax_f + 16'sd1;
    assign ax_w1   = ax_c[15:0];
    assign ax_w0   = 17'h10000 - {1'b0, ax_w1};
    assign ax_dim  = ax_sel_reg ? iw : ih;
    assign ax_lim  = $signed({8'b0, ax_dim}) - 16'sd1;

    always_comb
    begin
        if (ax_f < 16'sd0)
            ax_a = 7'd0;
        else if (ax_f > ax_lim)
            ax_a = ax_lim[6:0];
        else
            ax_a = ax_f[6:0];
        if (ax_f1 < 16'sd0)
            ax_b = 7'd0;
        else if (ax_f1 > ax_lim)
            ax_b = ax_lim[6:0];
        else
            ax_b = ax_f1[6:0];
    end

    logic [6:0]  y0_reg, y1_reg, x0_reg, x1_reg;
    logic [16:0] wy0_reg, wy1_reg, wx0_reg, wx1_reg;
    logic [14:0] rb0_reg, rb1_reg;
    logic [32:0] wc_reg [0:3];
    logic [1:0]  sub_reg;
    logic [33:0] wc_prod;

    assign wc_prod = (sub_reg[1] ? wy1_reg : wy0_reg) * (sub_reg[0] ? wx1_reg : wx0_reg);

    // channel loop
    logic [1:0]  oc_reg, k_reg, k_left_reg;
    logic [2:0]  count_reg;
    logic [42:0] acc_reg, mac_sum, rnd_sum;
    logic [1:0]  ch_first;
    logic [2:0]  ch_count;
    logic [14:0] rd_pix;
    logic [16:0] rd_addr17;
    logic [15:0] rd_addr;

    assign mac_sum   = acc_reg + 43'(wc_reg[sub_reg] * rdata_reg);
    assign rnd_sum   = mac_sum + {17'b0, count_reg, 23'b0};
    assign rd_pix    = (sub_reg[1] ? rb1_reg : rb0_reg) + {8'b0, (sub_reg[0] ? x1_reg : x0_reg)};
    assign rd_addr17 = 17'(rd_pix * ic) + {15'b0, k_reg};
    assign rd_addr   = rd_addr17[15:0];

    always_comb
    begin
        ch_first = 2'd0;
        ch_count = 3'd1;
        if (ic == ocn)
            ch_first = oc_reg;
        else if (ocn == 3'd1)
            ch_count = ic;
        else if (ic == 3'd1)
            ch_first = 2'd0;
        else if ({1'b0, oc_reg} < ic)
            ch_first = oc_reg;
        else
            ch_first = 2'(ic - 3'd1);
    end

    // load pointer wrap
    logic [16:0] size17;
    logic [15:0] lp_inc;
    assign size17 = 17'(hw_reg * ic);
    assign lp_inc = load_ptr_reg + 16'd1;

    // position advance
    logic [6:0] col_inc, row_inc;
    assign col_inc = {1'b0, out_col_reg} + 7'd1;
    assign row_inc = {1'b0, out_row_reg} + 7'd1;

    logic in_acc, load_we;
    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign in_acc    = in_valid && in_ready;
    assign load_we   = in_acc && (in_data.cmd == CMD_LOAD);

    // store: write on load, registered read for the accumulate
    always_ff @(posedge clk)
    begin
        if (load_we)
            frame_mem[load_ptr_reg] <= in_data.pixel_value;
        if (state_reg == ST_RD)
            rdata_reg <= frame_mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg    <= 8'd32;
            in_width_reg     <= 8'd32;
            in_channels_reg  <= 3'd1;
            out_height_reg   <= 7'd32;
            out_width_reg    <= 7'd32;
            out_channels_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_HEIGHT:    in_height_reg    <= cfg_data;
                REG_IN_WIDTH:     in_width_reg     <= cfg_data;
                REG_IN_CHANNELS:  in_channels_reg  <= cfg_data[2:0];
                REG_OUT_HEIGHT:   out_height_reg   <= cfg_data[6:0];
                REG_OUT_WIDTH:    out_width_reg    <= cfg_data[6:0];
                REG_OUT_CHANNELS: out_channels_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_ptr_reg  <= 16'd0;
            out_row_reg   <= 6'd0;
            out_col_reg   <= 6'd0;
            row_scale_reg <= 24'd0;
            col_scale_reg <= 24'd0;
            div_cnt_reg   <= 5'd0;
            div_quo_reg   <= 24'd0;
            div_rem_reg   <= 7'd0;
            div_den_reg   <= 7'd1;
            ax_sel_reg    <= 1'b0;
            sub_reg       <= 2'd0;
            oc_reg        <= 2'd0;
            k_reg         <= 2'd0;
            k_left_reg    <= 2'd0;
            count_reg     <= 3'd1;
            acc_reg       <= 43'd0;
            hw_reg        <= 15'd0;
            out_data      <= '0;
        end
        else
        begin
            // advance the divider while a division state is active and the division is not done
            if ((state_reg == ST_DIVR || state_reg == ST_DIVC || state_reg == ST_QD)
                && !div_done)
            begin
                div_rem_reg <= div_ge ? 7'(div_trial - {1'b0, div_den_reg}) : div_trial[6:0];
                div_quo_reg <= {div_quo_reg[22:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (in_data.cmd == CMD_LOAD)
                            state_reg <= ST_LD1;
                        else
                        begin
                            div_quo_reg <= {ih, 16'h0} + {18'b0, oh[6:1]};
                            div_den_reg <= oh;
                            div_rem_reg <= 7'd0;
                            div_cnt_reg <= 5'd0;
                            state_reg   <= ST_DIVR;
                        end
                    end
                end
                ST_LD1:
                begin
                    hw_reg    <= 15'(ih * iw);
                    state_reg <= ST_LD2;
                end
                ST_LD2:
                begin
                    load_ptr_reg <= ({1'b0, lp_inc} >= size17) ? 16'd0 : lp_inc;
                    state_reg    <= ST_IDLE;
                end
                ST_DIVR:
                begin
                    if (div_done)
                    begin
                        row_scale_reg <= div_quo_reg;
                        div_quo_reg   <= {iw, 16'h0} + {18'b0, ow[6:1]};
                        div_den_reg   <= ow;
                        div_rem_reg   <= 7'd0;
                        div_cnt_reg   <= 5'd0;
                        state_reg     <= ST_DIVC;
                    end
                end
                ST_DIVC:
                begin
                    if (div_done)
                    begin
                        col_scale_reg <= div_quo_reg;
                        ax_sel_reg    <= 1'b0;
                        state_reg     <= ST_AXM;
                    end
                end
                ST_AXM:
                begin
                    prod_reg  <= ax_prod;
                    state_reg <= ST_AXF;
                end
                ST_AXF:
                begin
                    if (!ax_sel_reg)
                    begin
                        y0_reg     <= ax_a;
                        y1_reg     <= ax_b;
                        wy0_reg    <= ax_w0;
                        wy1_reg    <= {1'b0, ax_w1};
                        ax_sel_reg <= 1'b1;
                        state_reg  <= ST_AXM;
                    end
                    else
                    begin
                        x0_reg    <= ax_a;
                        x1_reg    <= ax_b;
                        wx0_reg   <= ax_w0;
                        wx1_reg   <= {1'b0, ax_w1};
                        sub_reg   <= 2'd0;
                        state_reg <= ST_WGT;
                    end
                end
                ST_WGT:
                begin
                    wc_reg[sub_reg] <= wc_prod[32:0];
                    rb0_reg <= 15'(y0_reg * iw);
                    rb1_reg <= 15'(y1_reg * iw);
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd3)
                    begin
                        oc_reg    <= 2'd0;
                        state_reg <= ST_CH;
                    end
                end
                ST_CH:
                begin
                    k_reg      <= ch_first;
                    k_left_reg <= 2'(ch_count - 3'd1);
                    count_reg  <= ch_count;
                    sub_reg    <= 2'd0;
                    acc_reg    <= 43'd0;
                    state_reg  <= ST_RD;
                end
                ST_RD:
                    state_reg <= ST_MAC;
                ST_MAC:
                begin
                    acc_reg   <= mac_sum;
                    sub_reg   <= sub_reg + 2'd1;
                    state_reg <= ST_RD;
                    if (sub_reg == 2'd3)
                    begin
                        if (k_left_reg == 2'd0)
                        begin
                            div_quo_reg <= {5'b0, rnd_sum[42:24]};
                            div_den_reg <= {4'b0, count_reg};
                            div_rem_reg <= 7'd0;
                            div_cnt_reg <= 5'd0;
                            state_reg   <= ST_QD;
                        end
                        else
                        begin
                            k_reg      <= k_reg + 2'd1;
                            k_left_reg <= k_left_reg - 2'd1;
                        end
                    end
                end
                ST_QD:
                begin
                    if (div_done)
                    begin
                        out_data.sample_value  <= div_quo_reg[15:0];
                        out_data.channel_index <= oc_reg;
                        out_data.last_in_pixel <= {1'b0, oc_reg} == 3'(ocn - 3'd1);
                        out_data.last_in_frame <= ({1'b0, out_row_reg} == 7'(oh - 7'd1))
                                               && ({1'b0, out_col_reg} == 7'(ow - 7'd1));
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        if (out_data.last_in_pixel)
                        begin
                            if (col_inc >= ow)
                            begin
                                out_col_reg <= 6'd0;
                                out_row_reg <= (row_inc >= oh) ? 6'd0 : row_inc[5:0];
                            end
                            else
                                out_col_reg <= col_inc[5:0];
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            oc_reg    <= oc_reg + 2'd1;
                            state_reg <= ST_CH;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
